// ===== src/btstat_pkg.sv =====
// Shared types, constants and helper functions of the transmission statistic block.
`default_nettype none
package btstat_pkg;

  localparam int ValW  = 16;
  localparam int WgtW  = 24;
  localparam int ProdW = 42;
  localparam int RowW  = 48;
  localparam int BurW  = 64;
  localparam int CmcW  = 40;
  localparam int StatW = 32;
  localparam int RootW = 140;

  localparam logic [ValW-1:0] DenovoMark  = 16'd25600;
  localparam logic [ValW-1:0] OffAllowed  = 16'd25600;
  localparam logic [ValW-1:0] OffDefault  = 16'd25856;

  localparam logic [1:0] CfgTestMode    = 2'd0;
  localparam logic [1:0] CfgSkipMissing = 2'd1;
  localparam logic [1:0] CfgAllowDenovo = 2'd2;

  localparam logic [1:0] TestMother = 2'd1;
  localparam logic [1:0] TestFather = 2'd2;

  typedef struct packed {
    logic [1:0] parent_sel;
    logic       skip_missing;
    logic       allow_denovo;
  } cfg_t;

  typedef struct packed {
    logic [RowW-1:0] ru;
    logic [RowW-1:0] rt;
    logic [RowW-1:0] cb;
    logic [RowW-1:0] cc;
    logic            keep;
    logic            last;
  } row_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BURDEN, S_DIV, S_FRAC, S_ZPREP, S_SQ0, S_SQ1, S_SQ2, S_ROOT, S_ZDONE, S_OUT
  } back_state_e;

  function automatic logic [RowW-1:0] sat_row(input logic [RowW:0] v);
    logic [RowW-1:0] r;
    r = v[RowW-1:0];
    if (v[RowW] != v[RowW-1]) begin
      r = v[RowW] ? {1'b1, {(RowW-1){1'b0}}} : {1'b0, {(RowW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [BurW-1:0] sat_bur(input logic [BurW:0] v);
    logic [BurW-1:0] r;
    r = v[BurW-1:0];
    if (v[BurW] != v[BurW-1]) begin
      r = v[BurW] ? {1'b1, {(BurW-1){1'b0}}} : {1'b0, {(BurW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [CmcW-1:0] sat_cmc(input logic [CmcW+1:0] v);
    logic [CmcW-1:0] r;
    r = v[CmcW-1:0];
    if (v[CmcW+1] != v[CmcW] || v[CmcW] != v[CmcW-1]) begin
      r = v[CmcW+1] ? {1'b1, {(CmcW-1){1'b0}}} : {1'b0, {(CmcW-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [RowW-1:0] abs_row(input logic [RowW-1:0] v);
    return v[RowW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage
`default_nettype wire

// ===== src/btstat_front.sv =====
// Front part: element products, per-row sums and row records.
`default_nettype none
module btstat_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire btstat_pkg::cfg_t          cfg_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [15:0]               untrans_value_i,
  input  wire logic [15:0]               trans_value_i,
  input  wire logic [23:0]               site_weight_i,
  input  wire logic                      site_analyzed_i,
  input  wire logic                      last_in_row_i,
  input  wire logic                      last_in_table_i,
  input  wire btstat_pkg::q_stat_t       q_stat_i,
  output logic                           push_o,
  output btstat_pkg::row_rec_t           rec_o
);
  import btstat_pkg::*;

  logic                    busy_q;
  logic                    row_end_q, table_end_q;
  logic                    mother_q;
  logic signed [ProdW-1:0] pu_q, pt_q, pfu_q, pft_q;
  logic signed [ProdW-1:0] pu_d, pt_d, pfu_d, pft_d;
  logic [RowW-1:0]         su_q, st_q, sfu_q, sft_q;
  logic [RowW-1:0]         su_d, st_d, sfu_d, sft_d;
  logic signed [ValW:0]    tv, uv, fu, ft;
  logic signed [WgtW:0]    wv;
  logic                    accept, row_close, commit, keep;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !busy_q;

  always_comb begin
    uv = $signed({1'b0, untrans_value_i});
    tv = $signed({1'b0, trans_value_i});
    if (trans_value_i >= DenovoMark) begin
      tv = tv - $signed({1'b0, cfg_i.allow_denovo ? OffAllowed : OffDefault});
    end
    fu = {uv[ValW:8], 8'h00};
    ft = {tv[ValW:8], 8'h00};
    wv = $signed({1'b0, site_weight_i});
    if (site_analyzed_i) begin
      pu_d  = uv * wv;
      pt_d  = tv * wv;
      pfu_d = fu * wv;
      pft_d = ft * wv;
    end else begin
      pu_d  = '0;
      pt_d  = '0;
      pfu_d = '0;
      pft_d = '0;
    end
  end

  always_comb begin
    su_d  = sat_row({su_q[RowW-1], su_q} + {{(RowW+1-ProdW){pu_q[ProdW-1]}}, pu_q});
    st_d  = sat_row({st_q[RowW-1], st_q} + {{(RowW+1-ProdW){pt_q[ProdW-1]}}, pt_q});
    sfu_d = sat_row({sfu_q[RowW-1], sfu_q} + {{(RowW+1-ProdW){pfu_q[ProdW-1]}}, pfu_q});
    sft_d = sat_row({sft_q[RowW-1], sft_q} + {{(RowW+1-ProdW){pft_q[ProdW-1]}}, pft_q});
    case (cfg_i.parent_sel)
      TestMother: keep = mother_q;
      TestFather: keep = !mother_q;
      default:    keep = 1'b1;
    endcase
    rec_o.ru   = su_d;
    rec_o.rt   = st_d;
    rec_o.cb   = cfg_i.skip_missing ? su_d : sfu_d;
    rec_o.cc   = cfg_i.skip_missing ? st_d : sft_d;
    rec_o.keep = keep;
    rec_o.last = table_end_q;
  end

  assign row_close = row_end_q || table_end_q;
  assign commit    = busy_q && !(row_close && q_stat_i.full);
  assign push_o    = busy_q && row_close && !q_stat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      mother_q <= 1'b0;
      su_q     <= '0;
      st_q     <= '0;
      sfu_q    <= '0;
      sft_q    <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (commit) begin
        busy_q <= 1'b0;
        if (row_close) begin
          su_q     <= '0;
          st_q     <= '0;
          sfu_q    <= '0;
          sft_q    <= '0;
          mother_q <= table_end_q ? 1'b0 : !mother_q;
        end else begin
          su_q  <= su_d;
          st_q  <= st_d;
          sfu_q <= sfu_d;
          sft_q <= sft_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pu_q        <= pu_d;
      pt_q        <= pt_d;
      pfu_q       <= pfu_d;
      pft_q       <= pft_d;
      row_end_q   <= last_in_row_i;
      table_end_q <= last_in_table_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/btstat_queue.sv =====
// Two-entry row record queue between front and back.
`default_nettype none
module btstat_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire btstat_pkg::row_rec_t rec_i,
  input  wire logic                 pop_i,
  output btstat_pkg::row_rec_t      rec_o,
  output btstat_pkg::q_stat_t       stat_o
);
  import btstat_pkg::*;

  row_rec_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign rec_o        = mem_q[rd_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

endmodule
`default_nettype wire

// ===== src/btstat_back.sv =====
// Back part: totals, row fractions by restoring division, z statistics by digit square root.
`default_nettype none
module btstat_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire btstat_pkg::row_rec_t rec_i,
  input  wire btstat_pkg::q_stat_t  q_stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [31:0]               burden_stat_o,
  output logic                      burden_valid_o,
  output logic [31:0]               cmc_stat_o,
  output logic                      cmc_valid_o
);
  import btstat_pkg::*;

  back_state_e      state_q, state_d;
  row_rec_t         rec_q;
  logic [BurW-1:0]  bu_q, bt_q;
  logic [CmcW-1:0]  cu_q, ct_q;

  logic [63:0]      dn_q, quo_q;
  logic [RowW:0]    rem_q, ad_q;
  logic             dneg_q, dsgn_q, dsel_q;
  logic [5:0]       cnt_q;

  logic             zsel_q, zneg_q, zval_q;
  logic [63:0]      s_q, mag_q;
  logic [RootW-1:0] r_q, x_q, ts_q;
  logic [31:0]      qr_q;
  logic [4:0]       zcnt_q;

  logic [StatW-1:0] bs_q, cs_q;
  logic             bv_q, cv_q;
  logic             out_valid_q;
  logic [StatW-1:0] ob_q, oc_q;
  logic             obv_q, ocv_q;

  logic [RowW:0]    d_sum;
  logic             row_go;
  logic [RowW+1:0]  rem2;
  logic             dge;
  logic [CmcW:0]    mcap;
  logic [CmcW:0]    fmag;
  logic [CmcW+1:0]  frac, ftot;
  logic [BurW-1:0]  zb, zc;
  logic [BurW:0]    zsum, zdiff;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic [RootW-1:0] rt_t;
  logic             rge;
  logic [32:0]      qhi, qc;
  logic [StatW-1:0] zstat;
  logic             out_load;

  assign d_sum  = {rec_q.cb[RowW-1], rec_q.cb} + {rec_q.cc[RowW-1], rec_q.cc};
  assign row_go = rec_q.keep && (d_sum != '0);
  assign rem2   = {rem_q, dn_q[63]};
  assign dge    = rem2 >= {1'b0, ad_q};

  always_comb begin
    mcap = dneg_q ? {1'b1, {CmcW{1'b0}}} >> 1 : {2'b00, {(CmcW-1){1'b1}}};
    fmag = (quo_q > {{(64-CmcW-1){1'b0}}, mcap}) ? mcap : quo_q[CmcW:0];
    frac = dneg_q ? (~{1'b0, fmag} + 1'b1) : {1'b0, fmag};
    ftot = (dsel_q ? {{2{ct_q[CmcW-1]}}, ct_q} : {{2{cu_q[CmcW-1]}}, cu_q}) + frac;
  end

  always_comb begin
    zb    = zsel_q ? {{(BurW-CmcW){cu_q[CmcW-1]}}, cu_q} : bu_q;
    zc    = zsel_q ? {{(BurW-CmcW){ct_q[CmcW-1]}}, ct_q} : bt_q;
    zsum  = {zb[BurW-1], zb} + {zc[BurW-1], zc};
    zdiff = {zc[BurW-1], zc} - {zb[BurW-1], zb};
  end

  always_comb begin
    case (state_q)
      S_SQ1:   begin mul_a = mag_q[31:0];  mul_b = mag_q[63:32]; end
      S_SQ2:   begin mul_a = mag_q[63:32]; mul_b = mag_q[63:32]; end
      default: begin mul_a = mag_q[31:0];  mul_b = mag_q[31:0];  end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign rt_t  = x_q + ts_q;
  assign rge   = r_q >= rt_t;
  assign qhi   = zneg_q ? 33'h080000000 : 33'h07fffffff;
  assign qc    = ({1'b0, qr_q} > qhi) ? qhi : {1'b0, qr_q};
  assign zstat = zneg_q ? (~qc[31:0] + 1'b1) : qc[31:0];
  assign out_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = S_BURDEN;
        end
      end
      S_BURDEN: begin
        if (row_go)          state_d = S_DIV;
        else if (rec_q.last) state_d = S_ZPREP;
        else                 state_d = S_IDLE;
      end
      S_DIV:    if (cnt_q == 6'd63) state_d = S_FRAC;
      S_FRAC: begin
        if (!dsel_q)         state_d = S_DIV;
        else if (rec_q.last) state_d = S_ZPREP;
        else                 state_d = S_IDLE;
      end
      S_ZPREP: begin
        if (!zsum[BurW] && (zsum != '0)) state_d = S_SQ0;
        else                             state_d = S_ZDONE;
      end
      S_SQ0:   state_d = S_SQ1;
      S_SQ1:   state_d = S_SQ2;
      S_SQ2:   state_d = S_ROOT;
      S_ROOT:  if (zcnt_q == '0) state_d = S_ZDONE;
      S_ZDONE: state_d = zsel_q ? S_OUT : S_ZPREP;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      bu_q        <= '0;
      bt_q        <= '0;
      cu_q        <= '0;
      ct_q        <= '0;
      zsel_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_BURDEN: begin
          zsel_q <= 1'b0;
          if (rec_q.keep) begin
            bu_q <= sat_bur({bu_q[BurW-1], bu_q} +
                            {{(BurW+1-RowW){rec_q.ru[RowW-1]}}, rec_q.ru});
            bt_q <= sat_bur({bt_q[BurW-1], bt_q} +
                            {{(BurW+1-RowW){rec_q.rt[RowW-1]}}, rec_q.rt});
          end
        end
        S_FRAC: begin
          if (dsel_q) ct_q <= sat_cmc(ftot);
          else        cu_q <= sat_cmc(ftot);
        end
        S_ZDONE: zsel_q <= 1'b1;
        S_OUT: begin
          if (out_load) begin
            bu_q <= '0;
            bt_q <= '0;
            cu_q <= '0;
            ct_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (!q_stat_i.empty) rec_q <= rec_i;
      S_BURDEN: begin
        dn_q   <= {abs_row(rec_q.cb), 16'h0000};
        ad_q   <= d_sum[RowW] ? (~d_sum + 1'b1) : d_sum;
        dsgn_q <= d_sum[RowW];
        dneg_q <= rec_q.cb[RowW-1] ^ d_sum[RowW];
        rem_q  <= '0;
        quo_q  <= '0;
        cnt_q  <= '0;
        dsel_q <= 1'b0;
      end
      S_DIV: begin
        rem_q <= dge ? rem2[RowW:0] - ad_q : rem2[RowW:0];
        quo_q <= {quo_q[62:0], dge};
        dn_q  <= {dn_q[62:0], 1'b0};
        cnt_q <= cnt_q + 6'd1;
      end
      S_FRAC: begin
        dn_q   <= {abs_row(rec_q.cc), 16'h0000};
        dneg_q <= rec_q.cc[RowW-1] ^ dsgn_q;
        rem_q  <= '0;
        quo_q  <= '0;
        cnt_q  <= '0;
        dsel_q <= 1'b1;
      end
      S_ZPREP: begin
        s_q    <= zsum[63:0];
        zval_q <= !zsum[BurW] && (zsum != '0);
        zneg_q <= zdiff[BurW];
        mag_q  <= zdiff[BurW] ? (~zdiff[63:0] + 1'b1) : zdiff[63:0];
        qr_q   <= '0;
      end
      S_SQ0: r_q <= {{(RootW-64){1'b0}}, mul_p};
      S_SQ1: r_q <= r_q + ({{(RootW-64){1'b0}}, mul_p} << 33);
      S_SQ2: begin
        r_q    <= (r_q + ({{(RootW-64){1'b0}}, mul_p} << 64)) << (zsel_q ? 16 : 8);
        x_q    <= '0;
        ts_q   <= {{(RootW-64){1'b0}}, s_q} << 62;
        zcnt_q <= 5'd31;
      end
      S_ROOT: begin
        if (rge) r_q <= r_q - rt_t;
        qr_q   <= {qr_q[30:0], rge};
        x_q    <= (x_q >> 1) + (rge ? ts_q : '0);
        ts_q   <= ts_q >> 2;
        zcnt_q <= zcnt_q - 5'd1;
      end
      S_ZDONE: begin
        if (zsel_q) begin
          cs_q <= zval_q ? zstat : '0;
          cv_q <= zval_q;
        end else begin
          bs_q <= zval_q ? zstat : '0;
          bv_q <= zval_q;
        end
      end
      S_OUT: begin
        if (out_load) begin
          ob_q  <= bs_q;
          obv_q <= bv_q;
          oc_q  <= cs_q;
          ocv_q <= cv_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign burden_stat_o  = ob_q;
  assign burden_valid_o = obv_q;
  assign cmc_stat_o     = oc_q;
  assign cmc_valid_o    = ocv_q;

endmodule
`default_nettype wire

// ===== src/burden_transmission_statistic_top.sv =====
// Top level of the transmission burden and CMC statistic block.
//
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_ready_o   untrans, trans, weight, flags
//  out       output     out_valid_o / out_ready_i burden and CMC stat with valid flags
//  cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  The front takes no new element until the last one is through (product register, then row sums).
//  A kept row with a nonzero sum costs the back two 64-step divisions; a table end adds
//  two 32-step square roots and the output load.
//  Rows wait in a 2-entry queue; a row end stalls the front while the queue is full.
//  Reset clears all totals and control; config resets to mode 0, skip 1, denovo 0.
//  A stalled output holds its item; the front keeps accepting until the queue fills.
`default_nettype none
module burden_transmission_statistic_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [1:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] untrans_value_i,
  input  wire logic [15:0] trans_value_i,
  input  wire logic [23:0] site_weight_i,
  input  wire logic        site_analyzed_i,
  input  wire logic        last_in_row_i,
  input  wire logic        last_in_table_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      burden_stat_o,
  output logic             burden_valid_o,
  output logic [31:0]      cmc_stat_o,
  output logic             cmc_valid_o
);
  import btstat_pkg::*;

  cfg_t     cfg_q;
  row_rec_t push_rec, pop_rec;
  q_stat_t  q_stat;
  logic     push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.parent_sel   <= 2'd0;
      cfg_q.skip_missing <= 1'b1;
      cfg_q.allow_denovo <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTestMode:    cfg_q.parent_sel   <= cfg_data_i;
        CfgSkipMissing: cfg_q.skip_missing <= cfg_data_i[0];
        CfgAllowDenovo: cfg_q.allow_denovo <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  btstat_front u_front (
    .clk_i, .rst_ni,
    .cfg_i           (cfg_q),
    .in_valid_i, .in_ready_o,
    .untrans_value_i, .trans_value_i, .site_weight_i,
    .site_analyzed_i, .last_in_row_i, .last_in_table_i,
    .q_stat_i        (q_stat),
    .push_o          (push),
    .rec_o           (push_rec)
  );

  btstat_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (push),
    .rec_i  (push_rec),
    .pop_i  (pop),
    .rec_o  (pop_rec),
    .stat_o (q_stat)
  );

  btstat_back u_back (
    .clk_i, .rst_ni,
    .rec_i    (pop_rec),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_valid_o, .out_ready_i,
    .burden_stat_o, .burden_valid_o, .cmc_stat_o, .cmc_valid_o
  );

endmodule
`default_nettype wire

// ===== src/btstat_checker.sv =====
// Port-level assertions for the statistic block and their bind.
`default_nettype none
module btstat_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] burden_stat_o,
  input wire logic        burden_valid_o,
  input wire logic [31:0] cmc_stat_o,
  input wire logic        cmc_valid_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(burden_stat_o) && $stable(cmc_stat_o))
    else $error("output item changed while stalled");

  a_burden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !burden_valid_o |-> burden_stat_o == 32'd0)
    else $error("invalid burden stat not zero");

  a_cmc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cmc_valid_o |-> cmc_stat_o == 32'd0)
    else $error("invalid cmc stat not zero");

  a_front_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("front accepted items back to back");

endmodule

bind burden_transmission_statistic_top btstat_checker u_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .burden_stat_o, .burden_valid_o, .cmc_stat_o, .cmc_valid_o
);
`default_nettype wire

// ===== test/burden_transmission_statistic_top_tb.sv =====
// Testbench of the transmission burden and CMC statistic block, self-checking against a predictor.
`default_nettype none
module burden_transmission_statistic_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btstat_pkg::*;

  typedef struct {
    logic [15:0] untrans;
    logic [15:0] trans;
    logic [23:0] weight;
    logic        analyzed;
    logic        row_end;
    logic        table_end;
  } site_t;

  typedef struct {
    logic [31:0] bstat;
    logic        bvalid;
    logic [31:0] cstat;
    logic        cvalid;
  } stat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [1:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic [15:0] untrans_value_i = '0;
  logic [15:0] trans_value_i = '0;
  logic [23:0] site_weight_i = '0;
  logic        site_analyzed_i = 1'b0;
  logic        last_in_row_i = 1'b0;
  logic        last_in_table_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        cfg_ready_o, in_ready_o, out_valid_o;
  logic [31:0] burden_stat_o, cmc_stat_o;
  logic        burden_valid_o, cmc_valid_o;

  burden_transmission_statistic_top u_dut (.*);

  site_t  site_q[$];
  stat_t  stat_q[$];
  site_t  cur_site;
  bit     site_taken;
  bit     no_idle;
  int     hold_req, hold_seen, hold_cnt;
  int     errors;

  logic [1:0] m_mode;
  logic       m_skip, m_denovo;
  longint row_u, row_t, row_uf, row_tf, bur_u, bur_t, cmc_u, cmc_t;
  bit     row_mother;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("FAIL burden_transmission_statistic_top");
    $finish;
  end

  function automatic bit stall_now();
    return !no_idle && $urandom_range(99) < 6;
  endfunction

  function automatic longint clampn(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint sat_sum64(longint a, longint b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic longint row_share(longint n, longint d);
    bit neg;
    longint unsigned an, ad, cap, ip, rem, m;
    neg = (n < 0) != (d < 0);
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    cap = neg ? 64'h80_0000_0000 : 64'h7F_FFFF_FFFF;
    ip = an / ad;
    rem = an % ad;
    if (ip >= (64'd1 << 23)) m = cap;
    else m = (ip << 16) + (rem << 16) / ad;
    if (m > cap) m = cap;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic void z_score(input longint b, input longint c, input longint unsigned kk,
                                  output logic [31:0] z, output logic ok);
    longint unsigned s, mag, lo, hi, mid;
    bit pos, neg;
    logic [191:0] rhs, lhs;
    if (b >= 0 && c >= 0) begin
      s = b + c;
      pos = s != 0;
    end else if (b < 0 && c < 0) begin
      s = 0;
      pos = 0;
    end else begin
      pos = (b + c) > 0;
      s = pos ? b + c : 0;
    end
    ok = pos;
    z = '0;
    if (!pos) return;
    neg = c < b;
    mag = neg ? longint'(b) - longint'(c) : longint'(c) - longint'(b);
    rhs = 192'(mag) * 192'(mag) * 192'(kk);
    lo = 0;
    hi = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = 192'(mid * mid) * 192'(s);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    z = neg ? 32'(-lo) : 32'(lo);
  endfunction

  function automatic void clear_sums();
    row_u = 0; row_t = 0; row_uf = 0; row_tf = 0;
    row_mother = 0;
    bur_u = 0; bur_t = 0; cmc_u = 0; cmc_t = 0;
  endfunction

  function automatic void close_row();
    bit keep;
    longint b, c, d;
    keep = m_mode == TestMother ? row_mother : m_mode == TestFather ? !row_mother : 1'b1;
    if (keep) begin
      b = m_skip ? row_u : row_uf;
      c = m_skip ? row_t : row_tf;
      d = b + c;
      bur_u = sat_sum64(bur_u, row_u);
      bur_t = sat_sum64(bur_t, row_t);
      if (d != 0) begin
        cmc_u = clampn(cmc_u + row_share(b, d), CmcW);
        cmc_t = clampn(cmc_t + row_share(c, d), CmcW);
      end
    end
    row_u = 0; row_t = 0; row_uf = 0; row_tf = 0;
    row_mother = !row_mother;
  endfunction

  function automatic void accumulate_site(site_t s);
    longint u, t, w, fu, ft;
    stat_t r;
    if (s.analyzed) begin
      u = s.untrans;
      t = s.trans;
      w = s.weight;
      if (t >= DenovoMark) t -= m_denovo ? OffAllowed : OffDefault;
      fu = u - (u & 255);
      ft = t - (t & 255);
      row_u = clampn(row_u + u * w, RowW);
      row_t = clampn(row_t + t * w, RowW);
      row_uf = clampn(row_uf + fu * w, RowW);
      row_tf = clampn(row_tf + ft * w, RowW);
    end
    if (s.row_end || s.table_end) close_row();
    if (!s.table_end) return;
    z_score(bur_u, bur_t, 256, r.bstat, r.bvalid);
    z_score(cmc_u, cmc_t, 65536, r.cstat, r.cvalid);
    stat_q.insert(stat_q.size(), r);
    clear_sums();
  endfunction

  always @(posedge clk_i) begin
    stat_t e;
    if (out_valid_o && out_ready_i) begin
      if (stat_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %b %h %b",
                                   burden_stat_o, burden_valid_o, cmc_stat_o, cmc_valid_o);
      end else begin
        e = stat_q.pop_front();
        if (burden_stat_o !== e.bstat || burden_valid_o !== e.bvalid ||
            cmc_stat_o !== e.cstat || cmc_valid_o !== e.cvalid) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %h %b %h %b got %h %b %h %b", e.bstat, e.bvalid, e.cstat,
                     e.cvalid, burden_stat_o, burden_valid_o, cmc_stat_o, cmc_valid_o);
        end
      end
    end
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgTestMode:    m_mode = cfg_data_i;
        CfgSkipMissing: m_skip = cfg_data_i[0];
        CfgAllowDenovo: m_denovo = cfg_data_i[0];
        default: ;
      endcase
    end
    site_taken = in_valid_i && in_ready_o;
    if (site_taken) accumulate_site(cur_site);
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || site_taken)) begin
      if (site_q.size() > 0 && !stall_now()) begin
        cur_site = site_q.pop_front();
        untrans_value_i <= cur_site.untrans;
        trans_value_i <= cur_site.trans;
        site_weight_i <= cur_site.weight;
        site_analyzed_i <= cur_site.analyzed;
        last_in_row_i <= cur_site.row_end;
        last_in_table_i <= cur_site.table_end;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 3000;
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !stall_now();
    end
  end

  task automatic add_site(logic [15:0] u, logic [15:0] t, logic [23:0] w,
                          logic a, logic lr, logic lt);
    site_t s;
    s.untrans = u; s.trans = t; s.weight = w;
    s.analyzed = a; s.row_end = lr; s.table_end = lt;
    site_q.insert(site_q.size(), s);
  endtask

  function automatic logic [15:0] pick_value(bit trans);
    if (trans && $urandom_range(99) < 35) return 16'($urandom_range(65535, 25600));
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(767));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_weight();
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2, 3: return 24'($urandom_range(24'h1FFFF));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic add_table(int long_len);
    int rows, len;
    bit open_end;
    rows = long_len > 0 ? 2 : $urandom_range(6, 1);
    open_end = $urandom_range(99) < 15;
    for (int r = 0; r < rows; r++) begin
      len = long_len > 0 ? long_len : $urandom_range(5, 1);
      for (int k = 0; k < len; k++) begin
        if (long_len > 0)
          add_site(16'hFFFF, 16'h63FF, 24'hFFFFFF, 1'b1, k == len - 1, r == rows - 1 && k == len - 1);
        else
          add_site(pick_value(0), pick_value(1), pick_weight(), $urandom_range(99) < 85,
                   k == len - 1 && !(r == rows - 1 && open_end), r == rows - 1 && k == len - 1);
      end
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (site_q.size() > 0 || in_valid_i || stat_q.size() > 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  initial begin
    logic [1:0] modes[7] = '{2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1, 2'd0};
    logic       skips[7] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    logic       novos[7] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    int         start;
    m_mode = 2'd0; m_skip = 1'b1; m_denovo = 1'b0;
    clear_sums();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    add_site(16'd0, 16'd0, 24'd0, 1, 0, 0);
    add_site(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1, 0, 0);
    add_site(16'h1234, 16'd25600, 24'h010000, 1, 1, 0);
    add_site(16'd300, 16'd25855, 24'h008000, 1, 0, 0);
    add_site(16'd255, 16'hFFFF, 24'hFFFFFF, 0, 1, 1);
    add_site(16'd5, 16'd5, 24'd5, 0, 0, 1);
    add_site(16'd0, 16'd25600, 24'h010000, 1, 1, 0);
    add_site(16'd0, 16'd25700, 24'h020000, 1, 0, 1);
    add_site(16'hFFFF, 16'hFFFF, 24'd0, 1, 1, 1);
    add_site(16'd255, 16'd25600, 24'hFFFFFF, 1, 1, 0);
    add_site(16'd256, 16'd25599, 24'h0ABCDE, 1, 1, 1);
    add_site(16'd512, 16'd256, 24'h010000, 1, 1, 0);
    add_site(16'd0, 16'd25856, 24'h7FFFFF, 1, 1, 0);
    add_site(16'h8001, 16'h00FF, 24'h800001, 1, 0, 1);
    drain();

    for (int p = 0; p < 7; p++) begin
      cfg_write(CfgTestMode, modes[p]);
      cfg_write(CfgSkipMissing, {1'b0, skips[p]});
      cfg_write(CfgAllowDenovo, {1'b0, novos[p]});
      no_idle = p == 2;
      if (p == 3) hold_req++;
      if (p == 4) add_table(140);
      start = site_q.size();
      while (site_q.size() - start < 235) add_table(0);
      drain();
    end

    if (errors == 0 && stat_q.size() == 0) begin
      $display("PASS burden_transmission_statistic_top");
    end else begin
      $display("FAIL burden_transmission_statistic_top");
    end
    $finish;
  end

endmodule
`default_nettype wire
